>>> design/bounded_integer_set_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded integer set engine
// Clocked on clk, disabled while rst_n is low. ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_ENGINE_TOP_MACROS_SVH
`define BOUNDED_INTEGER_SET_ENGINE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, checked at every edge
`define BISE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent this cycle, consequent in the next
`define BISE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BISE_ASSERT(lbl, prop, msg)
`define BISE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/bise_pkg.sv
// ----------------------------------------------------------------------------
// bise_pkg
// Shared widths, request and status codes, and the result record.
// ----------------------------------------------------------------------------
package bise_pkg;

    localparam int DW            = 32;  // stored value width
    localparam int CW            = 7;   // entry count width
    localparam int REQ_W         = 3;
    localparam int STAT_W        = 2;
    localparam int SET_DEPTH_DEF = 64;

    // output tdata: status, found, element, count, zero pad to 48 bits
    localparam int OUT_FIELDS_W  = STAT_W + 1 + DW + CW;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SORT   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LIST   = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [DW-1:0]     element;
        logic              has_element;
        logic [CW-1:0]     count;
        logic              last;
    } res_t;

endpackage

>>> design/bise_outreg.sv
// ----------------------------------------------------------------------------
// bise_outreg
// Result holding register and master stream packing.
// ----------------------------------------------------------------------------
module bise_outreg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             res_push,
    input  bise_pkg::res_t                   res_in,
    output logic                             res_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [2] found, [34:3] element, [41:35] count, rest zero
    output logic [bise_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] has_element
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    logic           valid_reg;
    logic           valid_next;
    bise_pkg::res_t data_reg;

    assign res_ready  = !valid_reg || m_axis_tready;
    assign valid_next = res_push ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            data_reg <= res_in;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{bise_pkg::OUT_PAD_W{1'b0}}, data_reg.count, data_reg.element,
                            data_reg.found, data_reg.status};
    assign m_axis_tuser  = data_reg.has_element;
    assign m_axis_tlast  = data_reg.last;

endmodule

>>> design/bounded_integer_set_engine_top.sv
// Insert and query scan the n stored entries, one memory read per cycle through the single read
//   port. Remove of a present value also shifts the later entries down one place. Sort is an
//   insertion sort. List emits one entry per cycle while the output register can take it.
// Clear, unknown codes and sort of n <= 1 go straight to the response. A new request is taken
//   once the last result is in the output register. Reset zeroes the count; memory stays
//   undefined, no sweep.
// ----------------------------------------------------------------------------
// bounded_integer_set_engine_top
// Packed set of distinct signed 32-bit values held in a 1R1W synchronous memory,
// with insert, remove (compacting), query, clear, sort and list requests.
// ----------------------------------------------------------------------------
`include "bounded_integer_set_engine_top_macros.svh"

module bounded_integer_set_engine_top
#(
    parameter int SET_DEPTH = bise_pkg::SET_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] value
    input  logic [bise_pkg::DW-1:0]          s_axis_tdata,
    // [2:0] req_type
    input  logic [bise_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [2] found, [34:3] element, [41:35] count, [47:42] zero
    output logic [bise_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] has_element
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = bise_pkg::CW;
    localparam int DW = bise_pkg::DW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEARCH   = 4'd1;  // linear scan, one read per cycle
    localparam logic [3:0] S_SHIFT    = 4'd2;  // remove: move tail down one place
    localparam logic [3:0] S_SRT_KEY  = 4'd3;  // sort: read key at idx
    localparam logic [3:0] S_SRT_KEYW = 4'd4;  // sort: latch key, read left neighbor
    localparam logic [3:0] S_SRT_CMP  = 4'd5;  // sort: compare and move right
    localparam logic [3:0] S_SRT_PUT  = 4'd6;  // sort: key lands in slot 0
    localparam logic [3:0] S_LST_RD   = 4'd7;
    localparam logic [3:0] S_LST_OUT  = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;  // single result waits for the output reg

    // control state
    logic [3:0]    state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          rv_reg,     rv_next;    // rd_reg holds data for a scan compare or a shift

    // working registers
    logic [bise_pkg::REQ_W-1:0] op_reg, op_next;
    logic [DW-1:0] val_reg,  val_next;
    logic [CW-1:0] idx_reg,  idx_next;     // read pointer; outer index i during sort
    logic [CW-1:0] pos_reg,  pos_next;     // address behind rd_reg; hole j during sort
    logic [DW-1:0] key_reg,  key_next;
    bise_pkg::res_t res_reg, res_next;

    // memory ports
    logic [DW-1:0] mem_array [SET_DEPTH];
    logic [DW-1:0] rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // result hand-off to the output register
    logic           res_push;
    logic           res_ready;
    bise_pkg::res_t res_out;

    // arithmetic helpers
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] pos_dec;
    logic [CW-1:0] pos_dec2;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;
    logic          hit;
    logic          key_lt;
    logic          is_full;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign pos_inc  = pos_reg + CW'(1);
    assign pos_dec  = pos_reg - CW'(1);
    assign pos_dec2 = pos_reg - CW'(2);
    assign cnt_inc  = count_reg + CW'(1);
    assign cnt_dec  = count_reg - CW'(1);
    assign hit      = rv_reg && (rd_reg == val_reg);
    assign key_lt   = $signed(key_reg) < $signed(rd_reg);
    assign is_full  = count_reg >= CW'(SET_DEPTH);

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rv_next    = 1'b0;
        op_next    = op_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        res_push   = 1'b0;
        res_out    = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next              = s_axis_tuser;
                    val_next             = s_axis_tdata;
                    idx_next             = '0;
                    res_next.status      = bise_pkg::ST_DONE;
                    res_next.found       = 1'b0;
                    res_next.element     = '0;
                    res_next.has_element = 1'b0;
                    res_next.count       = count_reg;
                    res_next.last        = 1'b1;
                    unique case (s_axis_tuser) inside
                        bise_pkg::REQ_INSERT, bise_pkg::REQ_REMOVE, bise_pkg::REQ_QUERY:
                        begin
                            state_next = S_SEARCH;
                        end
                        bise_pkg::REQ_CLEAR:
                        begin
                            count_next     = '0;
                            res_next.count = '0;
                            state_next     = S_RESP;
                        end
                        bise_pkg::REQ_SORT:
                        begin
                            idx_next   = CW'(1);
                            state_next = (count_reg > CW'(1)) ? S_SRT_KEY : S_RESP;
                        end
                        bise_pkg::REQ_LIST:
                        begin
                            state_next = (count_reg == '0) ? S_RESP : S_LST_RD;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    case (op_reg)
                        bise_pkg::REQ_INSERT:
                        begin
                            res_next.status = bise_pkg::ST_PRESENT;
                            res_next.found  = 1'b1;
                            state_next      = S_RESP;
                        end
                        bise_pkg::REQ_REMOVE:
                        begin
                            idx_next   = pos_inc;
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            res_next.found = 1'b1;
                            state_next     = S_RESP;
                        end
                    endcase
                end
                else if (!rv_reg && (idx_reg >= count_reg))
                begin
                    // scan drained without a match
                    state_next = S_RESP;
                    if (op_reg == bise_pkg::REQ_INSERT)
                    begin
                        if (is_full)
                        begin
                            res_next.status = bise_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = count_reg[AW-1:0];
                            mem_wdata      = val_reg;
                            count_next     = cnt_inc;
                            res_next.count = cnt_inc;
                        end
                    end
                    else
                    begin
                        res_next.status = bise_pkg::ST_NOTFOUND;
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    pos_next  = idx_reg;
                    rv_next   = 1'b1;
                    idx_next  = idx_inc;
                end
            end

            S_SHIFT:
            begin
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_dec[AW-1:0];
                    mem_wdata = rd_reg;
                end
                if (idx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    pos_next  = idx_reg;
                    rv_next   = 1'b1;
                    idx_next  = idx_inc;
                end
                else if (!rv_reg)
                begin
                    count_next     = cnt_dec;
                    res_next.found = 1'b1;
                    res_next.count = cnt_dec;
                    state_next     = S_RESP;
                end
            end

            S_SRT_KEY:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_SRT_KEYW;
            end

            S_SRT_KEYW:
            begin
                key_next   = rd_reg;
                pos_next   = idx_reg;
                mem_re     = 1'b1;
                mem_raddr  = idx_dec[AW-1:0];
                state_next = S_SRT_CMP;
            end

            S_SRT_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                if (key_lt)
                begin
                    // neighbor moves right, hole moves left
                    mem_wdata = rd_reg;
                    pos_next  = pos_dec;
                    if (pos_reg == CW'(1))
                    begin
                        state_next = S_SRT_PUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_dec2[AW-1:0];
                    end
                end
                else
                begin
                    mem_wdata  = key_reg;
                    idx_next   = idx_inc;
                    state_next = (idx_inc == count_reg) ? S_RESP : S_SRT_KEY;
                end
            end

            S_SRT_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[AW-1:0];
                mem_wdata  = key_reg;
                idx_next   = idx_inc;
                state_next = (idx_inc == count_reg) ? S_RESP : S_SRT_KEY;
            end

            S_LST_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_LST_OUT;
            end

            S_LST_OUT:
            begin
                res_out.status      = bise_pkg::ST_DONE;
                res_out.found       = 1'b0;
                res_out.element     = rd_reg;
                res_out.has_element = 1'b1;
                res_out.count       = count_reg;
                res_out.last        = (idx_inc == count_reg);
                if (res_ready)
                begin
                    res_push = 1'b1;
                    if (idx_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // rd_reg only moves on a read, so a stall keeps the entry
                        mem_re    = 1'b1;
                        mem_raddr = idx_inc[AW-1:0];
                        idx_next  = idx_inc;
                    end
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem_array[mem_raddr];
        end
    end

    bise_outreg u_outreg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_push      (res_push),
        .res_in        (res_out),
        .res_ready     (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `BISE_ASSERT(a_count_bound, count_reg <= CW'(SET_DEPTH), "entry count above depth")
    `BISE_ASSERT(a_push_free, res_push |-> res_ready, "result pushed into a full output reg")
    `BISE_ASSERT(a_count_step,
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CW'(1)) ||
         (count_reg == $past(count_reg) - CW'(1)) || (count_reg == '0)),
        "count jumped")
    `BISE_ASSERT(a_sort_hole,
        ((state_reg == S_SRT_CMP) || (state_reg == S_SRT_PUT)) |->
        ((pos_reg <= idx_reg) && (idx_reg < count_reg)),
        "sort hole outside range")
    `BISE_ASSERT(a_shift_op, (state_reg == S_SHIFT) |-> (op_reg == bise_pkg::REQ_REMOVE), "compaction outside remove")
    `BISE_ASSERT_NEXT(a_resp_done, (state_reg == S_RESP) && res_ready, state_reg == S_IDLE,
        "response did not retire")

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: bounded integer set engine testbench
// Streams insert/remove/query/clear/sort/list requests through the block with
// bursty input and a stalling output side, predicts every response from a
// shadow copy of the set, and checks each response field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW           = bise_pkg::DW;
    localparam int CW           = bise_pkg::CW;
    localparam int REQ_W        = bise_pkg::REQ_W;
    localparam int STAT_W       = bise_pkg::STAT_W;
    localparam int OUT_TDATA_W  = bise_pkg::OUT_TDATA_W;
    localparam int OUT_FIELDS_W = bise_pkg::OUT_FIELDS_W;

    localparam int DEPTH        = bise_pkg::SET_DEPTH_DEF;
    localparam int RAND_ITEMS   = 310;      // random part length, in requests
    localparam int MAX_CYCLES   = 1000000;  // watchdog
    localparam int DRAIN_CYCLES = 200;      // quiet time after the last response
    localparam int STALL_CYCLES = 400;      // long output back-pressure
    localparam int HOLD_AT_A    = 60;       // request counts that start a long stall
    localparam int HOLD_AT_B    = 240;
    localparam int MAX_SHOWN    = 10;

    // codes the block does not decode; they still return one response
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic [DW-1:0]    value;
    } set_req_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DW-1:0]          s_axis_tdata  = '0;   // [31:0] value
    logic [REQ_W-1:0]       s_axis_tuser  = '0;   // [2:0] req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] status, [2] found, [34:3] element, [41:35] count, [47:42] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;         // [0] has_element
    logic                   m_axis_tlast;

    bounded_integer_set_engine_top
    #(
        .SET_DEPTH (DEPTH)
    )
    u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow set and response prediction
    // ------------------------------------------------------------------------
    logic [DW-1:0]  shadow_set [DEPTH];
    int unsigned    shadow_cnt = 0;
    bise_pkg::res_t expected_resps [$];   // responses owed by the block, oldest first
    set_req_t       pending_reqs [$];     // requests not yet offered on the input
    logic [DW-1:0]  used_vals [$];        // recent insert operands, reused for hits
    int unsigned    n_queued = 0;

    function automatic bise_pkg::res_t make_resp(logic [STAT_W-1:0] st, logic fnd,
                                                 logic [DW-1:0] el, logic has, logic lst);
        bise_pkg::res_t r;
        r.status      = st;
        r.found       = fnd;
        r.element     = el;
        r.has_element = has;
        r.count       = CW'(shadow_cnt);
        r.last        = lst;
        return r;
    endfunction

    // Applies one accepted request to the shadow set and queues its responses.
    function automatic void apply_set_request(set_req_t rq);
        int            pos;
        int            i;
        int            j;
        logic [DW-1:0] key;
        pos = -1;
        for (i = 0; i < int'(shadow_cnt); i++)
            if (pos < 0 && shadow_set[i] == rq.value)
                pos = i;
        case (rq.op)
            bise_pkg::REQ_INSERT:
                if (pos >= 0)
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_PRESENT, 1'b1, '0, 1'b0, 1'b1));
                else if (shadow_cnt >= DEPTH)
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_FULL, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    shadow_set[shadow_cnt] = rq.value;
                    shadow_cnt++;
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1));
                end
            bise_pkg::REQ_REMOVE:
                if (pos < 0)
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_NOTFOUND, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    // close the gap: later entries move down one slot
                    for (i = pos; i + 1 < int'(shadow_cnt); i++)
                        shadow_set[i] = shadow_set[i + 1];
                    shadow_cnt--;
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_DONE, 1'b1, '0, 1'b0, 1'b1));
                end
            bise_pkg::REQ_QUERY:
                if (pos < 0)
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_NOTFOUND, 1'b0, '0, 1'b0, 1'b1));
                else
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_DONE, 1'b1, '0, 1'b0, 1'b1));
            bise_pkg::REQ_CLEAR:
            begin
                shadow_cnt = 0;
                expected_resps.push_back(make_resp(bise_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1));
            end
            bise_pkg::REQ_SORT:
            begin
                // ascending by signed value, stable insertion sort
                for (i = 1; i < int'(shadow_cnt); i++)
                begin
                    key = shadow_set[i];
                    j   = i;
                    while (j > 0 && $signed(key) < $signed(shadow_set[j - 1]))
                    begin
                        shadow_set[j] = shadow_set[j - 1];
                        j--;
                    end
                    shadow_set[j] = key;
                end
                expected_resps.push_back(make_resp(bise_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1));
            end
            bise_pkg::REQ_LIST:
                if (shadow_cnt == 0)
                    expected_resps.push_back(
                        make_resp(bise_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1));
                else
                    for (i = 0; i < int'(shadow_cnt); i++)
                        expected_resps.push_back(
                            make_resp(bise_pkg::ST_DONE, 1'b0, shadow_set[i], 1'b1,
                                      i + 1 == int'(shadow_cnt)));
            default:
                expected_resps.push_back(make_resp(bise_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predicts on input transactions, checks output transactions.
    // Sampled at the rising edge, before the block's registers update.
    // ------------------------------------------------------------------------
    int unsigned n_req_acc    = 0;   // input transactions seen
    int unsigned n_req_issued = 0;   // requests put on the bus by the driver
    int unsigned n_errors     = 0;

    always @(posedge clk)
    begin : mon
        set_req_t       rq;
        bise_pkg::res_t got;
        bise_pkg::res_t want;
        if (rst_n)
        begin
            // predict first: a response could in principle share the edge
            if (s_axis_tvalid && s_axis_tready)
            begin
                rq.op    = s_axis_tuser;
                rq.value = s_axis_tdata;
                apply_set_request(rq);
                n_req_acc++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status      = m_axis_tdata[1:0];
                got.found       = m_axis_tdata[2];
                got.element     = m_axis_tdata[34:3];
                got.count       = m_axis_tdata[41:35];
                got.has_element = m_axis_tuser;
                got.last        = m_axis_tlast;
                if (expected_resps.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display({"[%0t] unexpected response: st=%0d f=%0b el=%h h=%0b ",
                                  "cnt=%0d l=%0b"},
                                 $time, got.status, got.found, got.element, got.has_element,
                                 got.count, got.last);
                end
                else
                begin
                    want = expected_resps.pop_front();
                    if (got !== want || m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN)
                            $display({"[%0t] response mismatch: exp st=%0d f=%0b el=%h h=%0b ",
                                      "cnt=%0d l=%0b | got st=%0d f=%0b el=%h h=%0b cnt=%0d ",
                                      "l=%0b pad=%h"},
                                     $time, want.status, want.found, want.element,
                                     want.has_element, want.count, want.last,
                                     got.status, got.found, got.element, got.has_element,
                                     got.count, got.last,
                                     m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers queued requests in bursts with random gaps.
    // Changes at the falling edge; valid holds until the transaction completes.
    // ------------------------------------------------------------------------
    int burst_left = 6;
    int gap_left   = 0;

    always @(negedge clk)
    begin : drv
        set_req_t         nxt;
        logic             nv;
        logic [REQ_W-1:0] nu;
        logic [DW-1:0]    nd;
        nv = s_axis_tvalid;
        nu = s_axis_tuser;
        nd = s_axis_tdata;
        if (rst_n)
        begin
            if (s_axis_tvalid && n_req_acc != n_req_issued)
            begin
                // offered but not yet taken: hold everything
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                nv = 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                nv  = 1'b1;
                nu  = nxt.op;
                nd  = nxt.value;
                n_req_issued++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1, 2:    gap_left = $urandom_range(1, 6);
                        default: gap_left = $urandom_range(10, 40);
                    endcase
                end
            end
            else
                nv = 1'b0;
        end
        s_axis_tvalid <= nv;
        s_axis_tuser  <= nu;
        s_axis_tdata  <= nd;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready pattern switches between random modes; twice in the run it
    // holds ready low for a long stall so the block backs up into its input.
    // ------------------------------------------------------------------------
    int hold_left = 0;
    int hold_idx  = 0;
    int rcv_mode  = 0;
    int mode_left = 0;

    always @(negedge clk)
    begin : rcv
        logic nr;
        nr = 1'b0;
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                rcv_mode  = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            else
                mode_left--;
            if (hold_left > 0)
                hold_left--;
            else if (hold_idx < 2 && n_req_acc >= (hold_idx == 0 ? HOLD_AT_A : HOLD_AT_B))
            begin
                hold_left = STALL_CYCLES;
                hold_idx++;
            end
            else
                case (rcv_mode)
                    0:       nr = 1'b1;
                    1:       nr = $urandom_range(0, 1);
                    2:       nr = ($urandom_range(0, 7) != 0);
                    default: nr = ($urandom_range(0, 3) == 0);
                endcase
        end
        m_axis_tready <= nr;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    int unsigned n_cycles = 0;

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= MAX_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_req(logic [REQ_W-1:0] op, logic [DW-1:0] v);
        set_req_t rq;
        rq.op    = op;
        rq.value = v;
        pending_reqs.push_back(rq);
        n_queued++;
        if (op == bise_pkg::REQ_INSERT)
        begin
            used_vals.push_back(v);
            if (used_vals.size() > DEPTH)
                void'(used_vals.pop_front());
        end
    endfunction

    // operand mix: earlier inserts (hits), small values, extremes, full random
    function automatic logic [DW-1:0] pick_value();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                v = (used_vals.size() != 0) ?
                    used_vals[$urandom_range(0, used_vals.size() - 1)] : $urandom;
            4, 5:
            begin
                v = $urandom_range(0, 15);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            6:
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    // Fills the set to capacity, then exercises full, duplicate, list, sort and
    // compaction on it. Half the time the fill order is strictly descending so
    // the sort sees reversed data.
    function automatic void push_fill_sequence();
        logic [DW-1:0] top;
        logic [DW-1:0] step;
        logic [DW-1:0] r;
        logic [DW-1:0] v;
        logic [DW-1:0] members [$];
        bit            descending;
        int            i;
        descending = $urandom_range(0, 1);
        top        = 32'h7FFF_FFFF - $urandom_range(0, 1000);
        step       = $urandom_range(1, 1 << 26);
        push_req(bise_pkg::REQ_CLEAR, $urandom);
        for (i = 0; i < DEPTH; i++)
        begin
            r = $urandom;
            // low bits carry the index in random order, so all values differ
            v = descending ? top - step * i : {r[DW-1:6], 6'(i)};
            members.push_back(v);
            push_req(bise_pkg::REQ_INSERT, v);
        end
        push_req(bise_pkg::REQ_INSERT, 32'h8000_0000);   // full (or duplicate)
        push_req(bise_pkg::REQ_INSERT, members[$urandom_range(0, DEPTH - 1)]);
        push_req(bise_pkg::REQ_QUERY, members[$urandom_range(0, DEPTH - 1)]);
        push_req(bise_pkg::REQ_LIST, $urandom);
        push_req(bise_pkg::REQ_SORT, $urandom);
        push_req(bise_pkg::REQ_LIST, $urandom);
        push_req(bise_pkg::REQ_REMOVE, members[0]);
        v = members[$urandom_range(1, DEPTH - 1)];
        push_req(bise_pkg::REQ_REMOVE, v);
        push_req(bise_pkg::REQ_REMOVE, v);               // now absent
        push_req(bise_pkg::REQ_INSERT, pick_value());
        push_req(bise_pkg::REQ_LIST, $urandom);
    endfunction

    task automatic wait_all_responses();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stim
        int               n_dir;
        int               r;
        logic [REQ_W-1:0] op;
        bit               mid_fill_done;
        mid_fill_done = 1'b0;

        // directed: empty-set cases, operand extremes, every opcode
        push_req(bise_pkg::REQ_LIST,   $urandom);        // empty list, single marker response
        push_req(bise_pkg::REQ_REMOVE, 32'd5);           // remove on empty keeps count at zero
        push_req(bise_pkg::REQ_QUERY,  32'h8000_0000);
        push_req(bise_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        push_req(bise_pkg::REQ_INSERT, 32'h8000_0000);
        push_req(bise_pkg::REQ_INSERT, 32'h0000_0000);
        push_req(bise_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        push_req(bise_pkg::REQ_INSERT, 32'h7FFF_FFFF);   // duplicate
        push_req(bise_pkg::REQ_QUERY,  32'h8000_0000);   // hit
        push_req(bise_pkg::REQ_QUERY,  32'h0001_2345);   // miss
        push_req(bise_pkg::REQ_REMOVE, 32'h0000_0000);   // middle entry, tail shifts down
        push_req(bise_pkg::REQ_REMOVE, 32'h0000_0000);   // now absent
        push_req(bise_pkg::REQ_LIST,   $urandom);
        push_req(bise_pkg::REQ_SORT,   $urandom);
        push_req(bise_pkg::REQ_LIST,   $urandom);
        push_req(REQ_RSVD6,            $urandom);        // undecoded codes
        push_req(REQ_RSVD7,            32'hFFFF_FFFF);
        push_req(bise_pkg::REQ_SORT,   32'h0000_0000);
        push_req(bise_pkg::REQ_CLEAR,  32'hFFFF_FFFF);
        push_req(bise_pkg::REQ_LIST,   32'h0000_0000);
        push_req(bise_pkg::REQ_SORT,   $urandom);        // sort of an empty set
        n_dir = n_queued;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender pause: let every directed response come back first
        wait_all_responses();

        // random part: two full-set sequences, the rest a weighted op mix
        push_fill_sequence();
        while (n_queued < n_dir + RAND_ITEMS)
        begin
            if (!mid_fill_done && n_queued >= n_dir + RAND_ITEMS / 2)
            begin
                push_fill_sequence();
                mid_fill_done = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    op = bise_pkg::REQ_INSERT;
                else if (r < 58)
                    op = bise_pkg::REQ_REMOVE;
                else if (r < 74)
                    op = bise_pkg::REQ_QUERY;
                else if (r < 82)
                    op = bise_pkg::REQ_LIST;
                else if (r < 88)
                    op = bise_pkg::REQ_SORT;
                else if (r < 92)
                    op = bise_pkg::REQ_CLEAR;
                else if (r < 96)
                    op = REQ_RSVD6;
                else
                    op = REQ_RSVD7;
                push_req(op, pick_value());
            end
        end

        wait_all_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bise_pkg.sv
design/bise_outreg.sv
design/bounded_integer_set_engine_top.sv
dv/tb.sv
